// File: rtl/sce_pkg.sv
// ----------------------------------------------------------------------------
// sce_pkg: shared types, codes and helpers of the SAT clause evaluator
// Holds the command and status codes, the variable state encoding and the
// structs that travel between the evaluator's modules.
// ----------------------------------------------------------------------------
package sce_pkg;

	localparam int NumVars = 1024;
	localparam int AddrW   = $clog2(NumVars);
	localparam int IdxW    = 10;
	localparam int StateW  = 3;

	typedef enum logic [1:0] {
		CMD_WRITE  = 2'd0,
		CMD_NEGATE = 2'd1,
		CMD_EVAL   = 2'd2,
		CMD_NONE   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		PROP_NONE        = 2'd0,
		PROP_CONFLICT    = 2'd1,
		PROP_IMPLY_FALSE = 2'd2,
		PROP_IMPLY_TRUE  = 2'd3
	} prop_t;

	typedef logic [StateW-1:0] var_state_t;

	localparam var_state_t ST_UNASSIGNED = 3'd0;
	localparam var_state_t ST_DECIDED0   = 3'd1;
	localparam var_state_t ST_DECIDED1   = 3'd2;
	localparam var_state_t ST_IMPLIED0   = 3'd3;
	localparam var_state_t ST_IMPLIED1   = 3'd4;

	typedef struct packed {
		cmd_t             cmd;
		logic [IdxW-1:0]  var_index;
		var_state_t       new_state;
		logic             literal_positive;
		logic             last_literal;
	} item_t;

	typedef struct packed {
		logic             en;
		logic [AddrW-1:0] addr;
		var_state_t       data;
	} wr_req_t;

	typedef struct packed {
		prop_t            prop_status;
		logic             clause_satisfied;
		logic [IdxW-1:0]  implied_var;
	} result_t;

	// Negation swaps the 0 and 1 forms; unassigned and undefined codes stay.
	function automatic var_state_t negate_state(var_state_t s);
		var_state_t r;
		case (s)
			ST_DECIDED0: r = ST_DECIDED1;
			ST_DECIDED1: r = ST_DECIDED0;
			ST_IMPLIED0: r = ST_IMPLIED1;
			ST_IMPLIED1: r = ST_IMPLIED0;
			default:     r = s;
		endcase
		return r;
	endfunction

	function automatic logic idx_in_range(logic [IdxW-1:0] idx);
		return 32'(idx) < 32'(NumVars);
	endfunction

	function automatic logic [AddrW-1:0] addr_of(logic [IdxW-1:0] idx);
		return AddrW'(idx);
	endfunction

endpackage

// File: rtl/sce_state_store.sv
// ----------------------------------------------------------------------------
// sce_state_store: variable state memory
// One write port and one registered read port. After reset a sweep writes
// every entry to unassigned, one entry per cycle, while busy is high.
// ----------------------------------------------------------------------------
module sce_state_store (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      rd_en,
	input  logic [sce_pkg::AddrW-1:0] rd_addr,
	output sce_pkg::var_state_t       rd_data,
	input  sce_pkg::wr_req_t          wr,
	output logic                      busy
);

	sce_pkg::var_state_t         mem [sce_pkg::NumVars];
	sce_pkg::var_state_t         rd_data_q;
	logic [sce_pkg::AddrW-1:0]   clr_addr_q;
	logic                        busy_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			if (clr_addr_q == sce_pkg::AddrW'(sce_pkg::NumVars - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (busy_q) begin
			mem[clr_addr_q] <= sce_pkg::ST_UNASSIGNED;
		end else if (wr.en) begin
			mem[wr.addr] <= wr.data;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	assign rd_data = rd_data_q;
	assign busy    = busy_q;

endmodule

// File: rtl/sce_lit_eval.sv
// ----------------------------------------------------------------------------
// sce_lit_eval: command execution and literal evaluation
// Works on the item held in the input register: forms the store write for
// write and negate commands, keeps the clause flags and builds the result
// of a clause on its last literal.
// ----------------------------------------------------------------------------
module sce_lit_eval (
	input  logic                clk,
	input  logic                arst_n,
	input  sce_pkg::item_t      item,
	input  sce_pkg::var_state_t stored,
	input  logic                fire,
	output sce_pkg::wr_req_t    wr,
	output logic                has_result,
	output sce_pkg::result_t    result
);

	logic                seen_unassigned_q;
	logic                seen_true_q;
	logic                in_range;
	sce_pkg::var_state_t cur;
	logic                unassigned;
	logic                value_one;
	logic                is_true;
	logic                all_assigned;
	logic                any_true;
	logic                is_eval;

	assign in_range   = sce_pkg::idx_in_range(item.var_index);
	assign cur        = in_range ? stored : sce_pkg::ST_UNASSIGNED;
	assign unassigned = (cur == sce_pkg::ST_UNASSIGNED);
	assign value_one  = !(cur == sce_pkg::ST_DECIDED0 || cur == sce_pkg::ST_IMPLIED0);
	assign is_true    = !unassigned && (value_one == item.literal_positive);
	assign is_eval    = (item.cmd == sce_pkg::CMD_EVAL);

	assign all_assigned = !seen_unassigned_q && !unassigned;
	assign any_true     = seen_true_q || is_true;
	assign has_result   = is_eval && item.last_literal;

	always_comb begin
		wr.en   = 1'b0;
		wr.addr = sce_pkg::addr_of(item.var_index);
		wr.data = item.new_state;
		case (item.cmd)
			sce_pkg::CMD_WRITE: begin
				wr.en = fire && in_range;
			end
			sce_pkg::CMD_NEGATE: begin
				wr.en   = fire && in_range;
				wr.data = sce_pkg::negate_state(cur);
			end
			default: begin
				wr.en = 1'b0;
			end
		endcase
	end

	always_comb begin
		if (all_assigned && !any_true) begin
			result.prop_status = sce_pkg::PROP_CONFLICT;
		end else if (!seen_unassigned_q && !seen_true_q) begin
			result.prop_status = item.literal_positive ? sce_pkg::PROP_IMPLY_TRUE
			                                           : sce_pkg::PROP_IMPLY_FALSE;
		end else begin
			result.prop_status = sce_pkg::PROP_NONE;
		end
		result.clause_satisfied = all_assigned && any_true;
		result.implied_var      = item.var_index;
	end

	// The flags describe the earlier literals of the clause in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seen_unassigned_q <= 1'b0;
			seen_true_q       <= 1'b0;
		end else if (fire && is_eval) begin
			if (item.last_literal) begin
				seen_unassigned_q <= 1'b0;
				seen_true_q       <= 1'b0;
			end else begin
				seen_unassigned_q <= seen_unassigned_q || unassigned;
				seen_true_q       <= seen_true_q || is_true;
			end
		end
	end

endmodule

// File: rtl/sat_clause_evaluator_core.sv
// ----------------------------------------------------------------------------
// sat_clause_evaluator_core: SAT clause evaluator top level
// Variable state store with write and negate commands, and a streaming
// clause check that reports satisfaction and unit propagation status.
// ----------------------------------------------------------------------------
// The block takes one word per cycle while the memory is not being swept
// and the output register is not stalled by a low m_tready. A word is
// registered in the input register together with the state memory read of
// its variable, evaluated from there and, for the last literal of a clause,
// placed in the output register when it leaves the input register. Writes
// and negations update the memory as they leave the input register and are
// forwarded to a word that reads the same variable right behind them. After
// reset the memory is swept to unassigned, during which s_tready stays low.
module sat_clause_evaluator_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,  // var_index[9:0], new_state[12:10], literal_positive[13]
	input  logic [1:0]  s_tuser,  // cmd[1:0]
	input  logic        s_tlast,  // last_literal
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata   // prop_status[1:0], clause_satisfied[2], implied_var[12:3]
);

	sce_pkg::item_t      in_item;
	sce_pkg::item_t      item_s1;
	logic                valid_s1;
	logic                byp_s1;
	sce_pkg::var_state_t byp_data_s1;
	sce_pkg::var_state_t rd_data;
	sce_pkg::var_state_t stored;
	sce_pkg::wr_req_t    wr;
	sce_pkg::result_t    result;
	logic                has_result;
	logic                busy;
	logic                accept;
	logic                adv_s1;
	logic                m_tvalid_q;
	logic [15:0]         m_tdata_q;

	assign in_item.cmd              = sce_pkg::cmd_t'(s_tuser);
	assign in_item.var_index        = s_tdata[9:0];
	assign in_item.new_state        = s_tdata[12:10];
	assign in_item.literal_positive = s_tdata[13];
	assign in_item.last_literal     = s_tlast;

	assign adv_s1   = valid_s1 && (!has_result || !m_tvalid_q || m_tready);
	assign s_tready = !busy && (!valid_s1 || adv_s1);
	assign accept   = s_tvalid && s_tready;

	sce_state_store u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (sce_pkg::addr_of(in_item.var_index)),
		.rd_data (rd_data),
		.wr      (wr),
		.busy    (busy)
	);

	assign stored = byp_s1 ? byp_data_s1 : rd_data;

	sce_lit_eval u_eval (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item_s1),
		.stored     (stored),
		.fire       (adv_s1),
		.wr         (wr),
		.has_result (has_result),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv_s1) begin
			valid_s1 <= 1'b0;
		end
	end

	// A write leaving the register in the same cycle as a read of the same
	// entry is not yet in the memory, so its data is carried alongside.
	always_ff @(posedge clk) begin
		if (accept) begin
			item_s1     <= in_item;
			byp_s1      <= wr.en && (wr.addr == sce_pkg::addr_of(in_item.var_index));
			byp_data_s1 <= wr.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (adv_s1 && has_result) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && has_result) begin
			m_tdata_q <= {3'b000, result.implied_var, result.clause_satisfied,
			              result.prop_status};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

endmodule
